### rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes, state type and control structs for the bounded deque
// no dependencies; imported by every module of the block

package bdq_pkg;

    // storage geometry
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int IDX_W1 = IDX_W + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int REM_W  = 6;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ_FWD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_BWD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_REMOVE,
        ST_RESULT
    } bdq_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;       // latch the incoming request
        logic dispatch;     // latch the single-result status
        logic push;         // write value at front or back
        logic clear;        // empty the store
        logic walk_start;   // start a walk at the first entry
        logic read_emit;    // send one read entry and advance
        logic rm_step;      // compact one entry and advance
        logic emit_single;  // send the single result
    } bdq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              full;
        logic              walk_last;
        logic              out_free;
    } bdq_sts_t;

    // ring position a + b modulo DEPTH, both below DEPTH
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= IDX_W1'(DEPTH))
        begin
            sum = sum - IDX_W1'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the bounded deque
// depends on bdq_pkg; drives commands into bdq_dpath

module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  bdq_sts_t sts,
    output bdq_cmd_t cmd
);

    bdq_state_t state_reg;
    bdq_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.mode)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_CLEAR:
                    begin
                        state_next = ST_RESULT;
                    end
                    MODE_READ_FWD, MODE_READ_BWD:
                    begin
                        state_next = sts.empty ? ST_RESULT : ST_READ;
                    end
                    MODE_REMOVE:
                    begin
                        state_next = sts.empty ? ST_RESULT : ST_REMOVE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                if (sts.out_free && sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REMOVE:
            begin
                if (sts.walk_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                case (sts.mode)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK:
                    begin
                        cmd.push = !sts.full;
                    end
                    MODE_READ_FWD, MODE_READ_BWD, MODE_REMOVE:
                    begin
                        cmd.walk_start = !sts.empty;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        cmd.dispatch = 1'b0;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.read_emit = sts.out_free;
            end
            ST_REMOVE:
            begin
                cmd.rm_step = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.emit_single = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/bdq_dpath.sv
`timescale 1ns / 1ps
// datapath for the bounded deque: entry memory, ring pointers, walk counters, result register
// depends on bdq_pkg; commanded by bdq_ctrl

module bdq_dpath
    import bdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdq_cmd_t                 cmd,
    output bdq_sts_t                 sts,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [DATA_W-1:0] data,
    output logic [STAT_W-1:0]        status,
    output logic [REM_W-1:0]         removed_count,
    output logic                     last
);

    // entry memory
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    // control state
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    // request and walk payload
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [REM_W-1:0]  res_removed_reg, res_removed_next;

    // result register
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [REM_W-1:0]  out_removed_reg, out_removed_next;
    logic              out_last_reg, out_last_next;

    // helpers
    logic              empty;
    logic              full;
    logic              walk_last;
    logic              out_free;
    logic              backward;
    logic [IDX_W-1:0]  k_sel;
    logic [CNT_W-1:0]  pos_wide;
    logic [IDX_W-1:0]  front_dec;
    logic              keep;
    logic [CNT_W-1:0]  kept_inc;
    logic [CNT_W-1:0]  removed_full;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign walk_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign backward  = (mode_reg == MODE_READ_BWD);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : (front_reg - IDX_W'(1));
    assign keep      = (rd_data_reg != value_reg);
    assign kept_inc  = kept_reg + CNT_W'(keep);
    assign removed_full = count_reg - kept_inc;

    assign sts.mode      = mode_reg;
    assign sts.empty     = empty;
    assign sts.full      = full;
    assign sts.walk_last = walk_last;
    assign sts.out_free  = out_free;

    // read address for the entry the walk visits next
    always_comb
    begin
        k_sel    = cmd.walk_start ? '0 : (k_reg + IDX_W'(1));
        pos_wide = backward ? (count_reg - CNT_W'(1) - CNT_W'(k_sel)) : CNT_W'(k_sel);
        rd_addr  = slot_add(front_reg, pos_wide[IDX_W-1:0]);
        rd_en    = cmd.walk_start
                || ((cmd.read_emit || cmd.rm_step) && !walk_last);
    end

    // memory write port: push or compaction
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_add(front_reg, count_reg[IDX_W-1:0]);
        wr_data = value_reg;
        if (cmd.push)
        begin
            wr_en = 1'b1;
            if (mode_reg == MODE_PUSH_FRONT)
            begin
                wr_addr = front_dec;
            end
        end
        else if (cmd.rm_step && keep)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_add(front_reg, kept_reg[IDX_W-1:0]);
            wr_data = rd_data_reg;
        end
    end

    // ring pointers, walk counters and pending result
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        kept_next        = kept_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;

        if (cmd.dispatch)
        begin
            res_removed_next = '0;
            if (mode_reg == MODE_PUSH_FRONT || mode_reg == MODE_PUSH_BACK)
            begin
                res_status_next = full ? STAT_FULL : STAT_OK;
            end
            else
            begin
                res_status_next = empty ? STAT_EMPTY : STAT_OK;
            end
        end

        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            if (mode_reg == MODE_PUSH_FRONT)
            begin
                front_next = front_dec;
            end
        end

        if (cmd.clear)
        begin
            count_next = '0;
            front_next = '0;
        end

        if (cmd.walk_start)
        begin
            k_next    = '0;
            kept_next = '0;
        end

        if (cmd.read_emit && !walk_last)
        begin
            k_next = k_reg + IDX_W'(1);
        end

        if (cmd.rm_step)
        begin
            kept_next = kept_inc;
            if (walk_last)
            begin
                count_next       = kept_inc;
                res_removed_next = REM_W'(removed_full);
                res_status_next  = (removed_full == '0) ? STAT_NOT_FOUND : STAT_OK;
            end
            else
            begin
                k_next = k_reg + IDX_W'(1);
            end
        end
    end

    // result register load and drain
    always_comb
    begin
        out_valid_next   = out_valid_reg && rsp_stall;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_last_next    = out_last_reg;
        if (cmd.read_emit)
        begin
            out_valid_next   = 1'b1;
            out_data_next    = rd_data_reg;
            out_status_next  = STAT_OK;
            out_removed_next = '0;
            out_last_next    = walk_last;
        end
        else if (cmd.emit_single)
        begin
            out_valid_next   = 1'b1;
            out_data_next    = '0;
            out_status_next  = res_status_reg;
            out_removed_next = res_removed_reg;
            out_last_next    = 1'b1;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        k_reg           <= k_next;
        kept_reg        <= kept_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp_valid     = out_valid_reg;
    assign data          = out_data_reg;
    assign status        = out_status_reg;
    assign removed_count = out_removed_reg;
    assign last          = out_last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_reg} < IDX_W1'(DEPTH))
        else $error("front index outside ring");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0 && front_reg == '0))
        else $error("clear did not empty the store");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("compaction write hits the entry being read");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read_emit || cmd.emit_single) |-> out_free)
        else $error("result loaded over an untaken result");

endmodule

### rtl/bounded_deque_remove_by_value.sv
`timescale 1ns / 1ps
// Bounded deque of up to DEPTH signed 32-bit entries in a ring buffer, with push front/back,
// read forward/backward, remove-by-value and clear. One request is worked at a time: a
// request is taken in one cycle and decoded in the next. A push or clear then delivers its
// single result from the result state. A read walks the entry memory through its registered
// read port, one entry per cycle while the result register is free. A remove compacts the
// survivors in place, reading one entry and writing one per cycle. Downstream stall holds a
// read walk and the result state until the result register is free. The result register
// lets the next request be taken while the last result still waits. Entries are not cleared
// at reset; only the front pointer, the count, the result valid flag and the state are.

module bounded_deque_remove_by_value
    import bdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [DATA_W-1:0] data,
    output logic [STAT_W-1:0]        status,
    output logic [REM_W-1:0]         removed_count,
    output logic                     last
);

    bdq_cmd_t cmd;
    bdq_sts_t sts;

    // sequencing of each request
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage, pointers and result register
    bdq_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .data          (data),
        .status        (status),
        .removed_count (removed_count),
        .last          (last)
    );

endmodule
